[hdl/icr_pkg.sv]
package icr_pkg;

    localparam int unsigned CHUNK_STRIDE_DEF = 235;
    localparam int unsigned ADDR_BITS_DEF    = 17;
    localparam int unsigned HDR_LEN          = 15;
    localparam int unsigned OUT_ADDR_W       = 17;
    localparam int unsigned CAP_W            = 18;
    localparam logic [CAP_W-1:0] CAP_RESET   = 18'd131072;
    localparam logic [7:0]  POS_MAX          = 8'd255;
    localparam int unsigned QUEUE_DEPTH      = 4;
    localparam int unsigned TDATA_W          = 128;

    typedef enum logic [2:0] {
        ST_SHORT    = 3'd0,
        ST_OVER_CAP = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_STORED   = 3'd4
    } status_t;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [OUT_ADDR_W-1:0]  write_address;
        logic [7:0]             write_byte;
        status_t                status;
        logic                   new_image;
        logic [31:0]            frame_id;
        logic [15:0]            chunk_number;
        logic [31:0]            received_bytes;
        logic [15:0]            battery_mv;
        logic                   image_complete;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

endpackage

[hdl/icr_core.sv]
module icr_core #(
    parameter int unsigned CHUNK_STRIDE = icr_pkg::CHUNK_STRIDE_DEF,
    parameter int unsigned ADDR_BITS    = icr_pkg::ADDR_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_fire,
    input  logic [7:0]                in_byte,
    input  logic                      in_last,
    input  logic [icr_pkg::CAP_W-1:0] capacity,
    output icr_pkg::push_t            push
);
    import icr_pkg::*;

    localparam int unsigned STRIDE_W = $clog2(CHUNK_STRIDE + 1);
    localparam int unsigned PROD_W   = 16 + STRIDE_W;
    localparam int unsigned END_W    = PROD_W + 1;
    localparam int unsigned MASK_W   = (ADDR_BITS < OUT_ADDR_W) ? ADDR_BITS : OUT_ADDR_W;
    localparam logic [7:0]  HDR_END  = 8'(HDR_LEN - 1);
    localparam logic [7:0]  DATA_POS = 8'(HDR_LEN);

    logic [7:0]        header_reg [HDR_LEN-1];
    logic [7:0]        pos_reg, pos_next;
    logic [31:0]       cur_image_reg, cur_image_next;
    logic [31:0]       image_size_reg, image_size_next;
    logic [31:0]       recv_count_reg, recv_count_next;
    logic              receiving_reg, receiving_next;
    logic              accepted_reg, accepted_next;
    status_t           status_reg, status_next;
    logic              started_reg, started_next;
    logic              complete_reg, complete_next;
    logic [15:0]       battery_reg, battery_next;
    logic [MASK_W-1:0] base_reg, base_next;

    logic [31:0]       id, total, size_eff, rc_base, rc_sum;
    logic [15:0]       idx, count;
    logic [7:0]        dlen, data_index;
    logic [PROD_W-1:0] prod;
    logic [END_W-1:0]  end_val;
    logic [MASK_W-1:0] addr;
    logic              is_new, over_cap, fits, done, bounds, full, write_ok;
    res_t              wr_res, st_res;

    assign id    = {header_reg[3], header_reg[2], header_reg[1], header_reg[0]};
    assign total = {header_reg[7], header_reg[6], header_reg[5], header_reg[4]};
    assign idx   = {header_reg[9], header_reg[8]};
    assign count = {header_reg[11], header_reg[10]};
    assign dlen  = header_reg[12];

    assign prod     = PROD_W'(idx) * PROD_W'(CHUNK_STRIDE);
    assign end_val  = END_W'(prod) + END_W'(dlen);
    assign is_new   = (idx == 16'd0) || (receiving_reg && (id != cur_image_reg));
    assign over_cap = total > 32'(capacity);
    assign size_eff = is_new ? total : image_size_reg;
    assign rc_base  = is_new ? 32'd0 : recv_count_reg;
    assign rc_sum   = rc_base + 32'(dlen);
    assign fits     = 32'(end_val) <= size_eff;
    assign done     = (rc_sum >= size_eff) && ((17'(idx) + 17'd1) == 17'(count));

    assign data_index = pos_reg - DATA_POS;
    assign addr       = base_reg + MASK_W'(data_index);
    assign write_ok   = (pos_reg >= DATA_POS) && (pos_reg < POS_MAX) && accepted_reg
                        && (data_index < dlen);

    always_comb begin
        pos_next        = pos_reg;
        cur_image_next  = cur_image_reg;
        image_size_next = image_size_reg;
        recv_count_next = recv_count_reg;
        receiving_next  = receiving_reg;
        accepted_next   = accepted_reg;
        status_next     = status_reg;
        started_next    = started_reg;
        complete_next   = complete_reg;
        battery_next    = battery_reg;
        base_next       = base_reg;
        bounds          = 1'b0;
        full            = pos_reg >= HDR_END;

        if (in_fire && (pos_reg == HDR_END)) begin
            if (is_new) begin
                image_size_next = total;
                if (over_cap) begin
                    receiving_next = 1'b0;
                    status_next    = ST_OVER_CAP;
                end else begin
                    cur_image_next  = id;
                    recv_count_next = 32'd0;
                    receiving_next  = 1'b1;
                    started_next    = 1'b1;
                    bounds          = 1'b1;
                end
            end else if (!receiving_reg || (id != cur_image_reg)) begin
                status_next = ST_DROPPED;
            end else begin
                bounds = 1'b1;
            end
            if (bounds) begin
                if (fits) begin
                    accepted_next   = 1'b1;
                    recv_count_next = rc_sum;
                    battery_next    = {header_reg[13], in_byte};
                    status_next     = ST_STORED;
                    base_next       = prod[MASK_W-1:0];
                    if (done) begin
                        complete_next  = 1'b1;
                        receiving_next = 1'b0;
                    end
                end else begin
                    status_next    = ST_OVERFLOW;
                    receiving_next = 1'b0;
                end
            end
        end

        wr_res               = '0;
        wr_res.kind          = KIND_WRITE;
        wr_res.status        = ST_SHORT;
        wr_res.write_address = OUT_ADDR_W'(addr);
        wr_res.write_byte    = in_byte;

        st_res                = '0;
        st_res.kind           = KIND_STATUS;
        st_res.status         = full ? status_next : ST_SHORT;
        st_res.new_image      = full && started_next;
        st_res.frame_id       = full ? id : 32'd0;
        st_res.chunk_number   = full ? idx : 16'd0;
        st_res.received_bytes = recv_count_next;
        st_res.battery_mv     = battery_next;
        st_res.image_complete = full && complete_next;

        push = '0;
        if (in_fire) begin
            if (write_ok) begin
                push.first  = wr_res;
                push.second = st_res;
                push.count  = in_last ? 2'd2 : 2'd1;
            end else begin
                push.first = st_res;
                push.count = in_last ? 2'd1 : 2'd0;
            end
            if (in_last) begin
                pos_next      = 8'd0;
                accepted_next = 1'b0;
                status_next   = ST_SHORT;
                started_next  = 1'b0;
                complete_next = 1'b0;
            end else if (pos_reg < POS_MAX) begin
                pos_next = pos_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && (pos_reg < HDR_END)) begin
            header_reg[pos_reg[3:0]] <= in_byte;
        end
        base_reg <= base_next;
        if (!aresetn) begin
            pos_reg        <= 8'd0;
            cur_image_reg  <= 32'd0;
            image_size_reg <= 32'd0;
            recv_count_reg <= 32'd0;
            receiving_reg  <= 1'b0;
            accepted_reg   <= 1'b0;
            status_reg     <= ST_SHORT;
            started_reg    <= 1'b0;
            complete_reg   <= 1'b0;
            battery_reg    <= 16'd0;
        end else begin
            pos_reg        <= pos_next;
            cur_image_reg  <= cur_image_next;
            image_size_reg <= image_size_next;
            recv_count_reg <= recv_count_next;
            receiving_reg  <= receiving_next;
            accepted_reg   <= accepted_next;
            status_reg     <= status_next;
            started_reg    <= started_next;
            complete_reg   <= complete_next;
            battery_reg    <= battery_next;
        end
    end

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_last |=> (pos_reg == 8'd0) && !accepted_reg && !complete_reg)
        else $error("packet state not cleared after the last word");

    a_complete_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        complete_reg |-> (status_reg == ST_STORED) && !receiving_reg)
        else $error("completion flagged without a stored chunk");

    a_accept_in_data: assert property (@(posedge aclk) disable iff (!aresetn)
        accepted_reg |-> (pos_reg >= DATA_POS))
        else $error("chunk accepted before the header was complete");

endmodule

[hdl/icr_out_queue.sv]
module icr_out_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  icr_pkg::push_t push,
    output logic           in_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output icr_pkg::res_t  m_res
);
    import icr_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    res_t             q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign m_valid  = count_reg != '0;
    assign m_res    = q_reg[rd_ptr_reg];
    assign pop      = m_valid && m_ready;
    assign in_ready = count_reg <= CNT_W'(QUEUE_DEPTH - 2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            q_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            q_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/image_chunk_reassembler.sv]
// Image chunk reassembler: takes radio packets one byte per word on the slave stream, with
// tlast on the final byte, parses the fifteen-byte header and emits one memory-write word
// per stored data byte followed by a status word at the end of every packet, the kind being
// given in m_tuser. Input bytes are accepted at one per cycle while s_tready is high; each
// byte is handled in a single pass between the header and state registers and a four-word
// result queue, and s_tready stays high while no more than two results are queued, so the
// closing byte of a packet that also carries a data write pushes two results into the
// queue. There is no clearing pass after reset. The buffer_capacity register at address 0
// is to be written over APB only while the block is idle; the block does not enforce this.
module image_chunk_reassembler #(
    parameter int unsigned CHUNK_STRIDE = icr_pkg::CHUNK_STRIDE_DEF,
    parameter int unsigned ADDR_BITS    = icr_pkg::ADDR_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // packet_byte
    input  logic                        s_tlast,  // last_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // write_address, write_byte, status, new_image, frame_id, chunk_number,
    // received_bytes, battery_mv, image_complete, zero padding
    output logic [icr_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tuser,  // kind
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import icr_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    logic             in_fire;
    push_t            push;
    res_t             res;

    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : 32'(capacity_reg);
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    icr_core #(
        .CHUNK_STRIDE(CHUNK_STRIDE),
        .ADDR_BITS   (ADDR_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .capacity(capacity_reg),
        .push    (push)
    );

    icr_out_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .in_ready(s_tready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    assign m_tuser = res.kind;
    assign m_tdata = {2'b00, res.image_complete, res.battery_mv, res.received_bytes,
                      res.chunk_number, res.frame_id, res.new_image, res.status,
                      res.write_byte, res.write_address};

endmodule
